// ----- hw/rtl/rsnh_pkg.sv -----
// Shared types, widths and codes for the ray/sphere nearest-hit block.
package rsnh_pkg;

    localparam int MAX_SPHERES_DEF = 16;

    // Field widths
    localparam int ENTRY_W = 4;
    localparam int PT_W    = 48;
    localparam int RAD_W   = 47;
    localparam int DIR_W   = 32;
    localparam int DIST_W  = 47;
    localparam int CNT_W   = 5;
    localparam int MIN_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd1;
    localparam logic [MIN_W-1:0]     MIN_DIST_RST     = 16'd7;

    // Commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RAY  = 1'b1;

    // Datapath widths
    localparam int OP_W  = PT_W + 1;        // center - origin
    localparam int MAG_W = PT_W;            // |op|
    localparam int BP_W  = OP_W + DIR_W;    // op * d
    localparam int BI_W  = BP_W - 30;       // floor(op * d / 2^30)
    localparam int B_W   = BI_W + 1;        // b, sum of three
    localparam int BM_W  = B_W - 1;         // |b|
    localparam int SQ_O_W = 2 * MAG_W;      // op_i^2
    localparam int NN_W  = SQ_O_W + 2;      // op.op
    localparam int RR_W  = 2 * RAD_W;       // r^2
    localparam int BB_W  = 2 * BM_W;        // b^2
    localparam int DET_W = BB_W + 2;        // b^2 + r^2 - op.op
    localparam int SQ_W  = DET_W / 2;       // sqrt(det)
    localparam int R_W   = SQ_W + 2;        // sqrt remainder
    localparam int T_W   = SQ_W + 2;        // b +/- s

    typedef struct packed {
        logic                    command;
        logic [ENTRY_W-1:0]      entry_index;
        logic signed [PT_W-1:0]  point_x;
        logic signed [PT_W-1:0]  point_y;
        logic signed [PT_W-1:0]  point_z;
        logic [RAD_W-1:0]        sphere_size;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] hit_index;
        logic [DIST_W-1:0]  hit_distance;
    } t_rsp;

    typedef struct packed {
        logic signed [PT_W-1:0] cx;
        logic signed [PT_W-1:0] cy;
        logic signed [PT_W-1:0] cz;
        logic [RAD_W-1:0]       rad;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/ray_sphere_nearest_hit.sv -----
// A ray request scans the first n table entries, n = min(sphere_count, MAX_SPHERES);
//   with n = 0 it goes straight to the done state and the response is a miss.
// Throughput: one sphere test per cycle through a 65-stage test pipeline
//   (multiply stages plus a one-bit-per-stage square root); one ray is in flight at a time.
// A load request writes the table on acceptance. A ray holds the input (ready low)
//   until its response has moved to the output register. Reset (sync, active low) clears
//   control and sphere_count, sets min_distance to 7; the sphere table is undefined.
module ray_sphere_nearest_hit #(
    parameter int MAX_SPHERES = rsnh_pkg::MAX_SPHERES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  rsnh_pkg::t_req                    i_req,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_ready,
    output rsnh_pkg::t_rsp                    o_rsp,
    input  logic                              i_cfg_we,
    input  logic [rsnh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rsnh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int NCNT_W = $clog2(MAX_SPHERES + 1);

    localparam int OP_W   = rsnh_pkg::OP_W;
    localparam int MAG_W  = rsnh_pkg::MAG_W;
    localparam int BP_W   = rsnh_pkg::BP_W;
    localparam int B_W    = rsnh_pkg::B_W;
    localparam int BM_W   = rsnh_pkg::BM_W;
    localparam int SQ_O_W = rsnh_pkg::SQ_O_W;
    localparam int NN_W   = rsnh_pkg::NN_W;
    localparam int RR_W   = rsnh_pkg::RR_W;
    localparam int BB_W   = rsnh_pkg::BB_W;
    localparam int DET_W  = rsnh_pkg::DET_W;
    localparam int SQ_W   = rsnh_pkg::SQ_W;
    localparam int R_W    = rsnh_pkg::R_W;
    localparam int T_W    = rsnh_pkg::T_W;
    localparam int DIST_W = rsnh_pkg::DIST_W;
    localparam int DIR_W  = rsnh_pkg::DIR_W;
    localparam int PT_W   = rsnh_pkg::PT_W;
    localparam int RAD_W  = rsnh_pkg::RAD_W;

    // ---------------- configuration ----------------
    logic [rsnh_pkg::CNT_W-1:0] r_sphere_count;
    logic [rsnh_pkg::MIN_W-1:0] r_min_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sphere_count <= '0;
            r_min_distance <= rsnh_pkg::MIN_DIST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rsnh_pkg::CFG_SPHERE_COUNT: r_sphere_count <= i_cfg_data[rsnh_pkg::CNT_W-1:0];
                rsnh_pkg::CFG_MIN_DISTANCE: r_min_distance <= i_cfg_data[rsnh_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- control ----------------
    rsnh_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]  r_scan_idx, n_scan_idx;
    logic [NCNT_W-1:0] r_scan_left, n_scan_left;
    logic              issue, issue_last, out_load;
    logic              req_fire, ray_fire, load_we;
    logic [8:0]        cnt_ext, entry_ext;
    logic [NCNT_W-1:0] scan_n;

    logic              r_t2_v, r_t2_last, r_t2_ok;
    logic signed [T_W-1:0] r_t2_t;
    logic [IDX_W-1:0]  r_t2_idx;

    assign o_req_ready = (r_state == rsnh_pkg::ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign ray_fire    = req_fire && (i_req.command == rsnh_pkg::CMD_RAY);
    assign entry_ext   = 9'(i_req.entry_index);
    assign load_we     = req_fire && (i_req.command == rsnh_pkg::CMD_LOAD)
                         && (entry_ext < 9'(MAX_SPHERES));

    assign cnt_ext = 9'(r_sphere_count);
    assign scan_n  = (cnt_ext > 9'(MAX_SPHERES)) ? NCNT_W'(MAX_SPHERES)
                                                 : cnt_ext[NCNT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_scan_idx  = r_scan_idx;
        n_scan_left = r_scan_left;
        issue       = 1'b0;
        issue_last  = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            rsnh_pkg::ST_IDLE: begin
                if (ray_fire) begin
                    if (scan_n == '0) begin
                        n_state = rsnh_pkg::ST_DONE;
                    end else begin
                        n_state     = rsnh_pkg::ST_SCAN;
                        n_scan_idx  = IDX_W'(scan_n - NCNT_W'(1));
                        n_scan_left = scan_n;
                    end
                end
            end
            rsnh_pkg::ST_SCAN: begin
                // highest index first so that ties keep the higher index
                issue       = 1'b1;
                issue_last  = (r_scan_left == NCNT_W'(1));
                n_scan_idx  = r_scan_idx - IDX_W'(1);
                n_scan_left = r_scan_left - NCNT_W'(1);
                if (issue_last) begin
                    n_state = rsnh_pkg::ST_WAIT;
                end
            end
            rsnh_pkg::ST_WAIT: begin
                if (r_t2_v && r_t2_last) begin
                    n_state = rsnh_pkg::ST_DONE;
                end
            end
            rsnh_pkg::ST_DONE: begin
                if (!o_rsp_valid || i_rsp_ready) begin
                    out_load = 1'b1;
                    n_state  = rsnh_pkg::ST_IDLE;
                end
            end
            default: n_state = rsnh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsnh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx  <= n_scan_idx;
        r_scan_left <= n_scan_left;
    end

    // ray held for the whole scan
    logic signed [PT_W-1:0]  r_org [3];
    logic signed [DIR_W-1:0] r_dir [3];

    always_ff @(posedge i_clk) begin
        if (ray_fire) begin
            r_org[0] <= i_req.point_x;
            r_org[1] <= i_req.point_y;
            r_org[2] <= i_req.point_z;
            r_dir[0] <= i_req.dir_x;
            r_dir[1] <= i_req.dir_y;
            r_dir[2] <= i_req.dir_z;
        end
    end

    // ---------------- sphere table ----------------
    rsnh_pkg::t_entry wr_entry, rd_entry;
    logic [$bits(rsnh_pkg::t_entry)-1:0] rd_data;

    always_comb begin
        wr_entry.cx  = i_req.point_x;
        wr_entry.cy  = i_req.point_y;
        wr_entry.cz  = i_req.point_z;
        wr_entry.rad = i_req.sphere_size;
    end

    rsnh_ram #(
        .WIDTH ($bits(rsnh_pkg::t_entry)),
        .DEPTH (MAX_SPHERES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (entry_ext[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_scan_idx),
        .o_rdata (rd_data)
    );

    assign rd_entry = rd_data;

    // ---------------- test pipeline ----------------
    // stage valids, tags
    logic r_p0_v, r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v;
    logic r_p6_v, r_p7_v, r_p8_v, r_p9_v, r_t1_v;
    logic r_p0_last, r_p1_last, r_p2_last, r_p3_last, r_p4_last, r_p5_last;
    logic r_p6_last, r_p7_last, r_p8_last, r_p9_last, r_t1_last;
    logic [IDX_W-1:0] r_p0_idx, r_p1_idx, r_p2_idx, r_p3_idx, r_p4_idx, r_p5_idx;
    logic [IDX_W-1:0] r_p6_idx, r_p7_idx, r_p8_idx, r_p9_idx, r_t1_idx;

    logic [R_W-1:0]        r_sq_rem  [SQ_W+1];
    logic [SQ_W-1:0]       r_sq_root [SQ_W+1];
    logic [DET_W-1:0]      r_sq_det  [SQ_W+1];
    logic signed [B_W-1:0] r_sq_b    [SQ_W+1];
    logic                  r_sq_v    [SQ_W+1];
    logic                  r_sq_ok   [SQ_W+1];
    logic                  r_sq_last [SQ_W+1];
    logic [IDX_W-1:0]      r_sq_idx  [SQ_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v    <= 1'b0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_p3_v    <= 1'b0;
            r_p4_v    <= 1'b0;
            r_p5_v    <= 1'b0;
            r_p6_v    <= 1'b0;
            r_p7_v    <= 1'b0;
            r_p8_v    <= 1'b0;
            r_p9_v    <= 1'b0;
            r_sq_v[0] <= 1'b0;
            r_t1_v    <= 1'b0;
            r_t2_v    <= 1'b0;
        end else begin
            r_p0_v    <= issue;
            r_p1_v    <= r_p0_v;
            r_p2_v    <= r_p1_v;
            r_p3_v    <= r_p2_v;
            r_p4_v    <= r_p3_v;
            r_p5_v    <= r_p4_v;
            r_p6_v    <= r_p5_v;
            r_p7_v    <= r_p6_v;
            r_p8_v    <= r_p7_v;
            r_p9_v    <= r_p8_v;
            r_sq_v[0] <= r_p9_v;
            r_t1_v    <= r_sq_v[SQ_W];
            r_t2_v    <= r_t1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_idx     <= r_scan_idx;
        r_p0_last    <= issue_last;
        r_p1_idx     <= r_p0_idx;
        r_p1_last    <= r_p0_last;
        r_p2_idx     <= r_p1_idx;
        r_p2_last    <= r_p1_last;
        r_p3_idx     <= r_p2_idx;
        r_p3_last    <= r_p2_last;
        r_p4_idx     <= r_p3_idx;
        r_p4_last    <= r_p3_last;
        r_p5_idx     <= r_p4_idx;
        r_p5_last    <= r_p4_last;
        r_p6_idx     <= r_p5_idx;
        r_p6_last    <= r_p5_last;
        r_p7_idx     <= r_p6_idx;
        r_p7_last    <= r_p6_last;
        r_p8_idx     <= r_p7_idx;
        r_p8_last    <= r_p7_last;
        r_p9_idx     <= r_p8_idx;
        r_p9_last    <= r_p8_last;
        r_sq_idx[0]  <= r_p9_idx;
        r_sq_last[0] <= r_p9_last;
        r_t1_idx     <= r_sq_idx[SQ_W];
        r_t1_last    <= r_sq_last[SQ_W];
        r_t2_idx     <= r_t1_idx;
        r_t2_last    <= r_t1_last;
    end

    // P1: op = center - origin
    logic signed [PT_W-1:0] ent_c [3];
    logic signed [OP_W-1:0] r_p1_op [3];
    logic [RAD_W-1:0]       r_p1_r;

    assign ent_c[0] = rd_entry.cx;
    assign ent_c[1] = rd_entry.cy;
    assign ent_c[2] = rd_entry.cz;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_p1_op[a] <= OP_W'(ent_c[a]) - OP_W'(r_org[a]);
        end
        r_p1_r <= rd_entry.rad;
    end

    // P2: magnitudes
    logic signed [OP_W-1:0] r_p2_op  [3];
    logic [MAG_W-1:0]       r_p2_mag [3];
    logic [RAD_W-1:0]       r_p2_r;
    logic [OP_W-1:0]        p2_neg   [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            p2_neg[a] = r_p1_op[a][OP_W-1] ? (OP_W'(0) - r_p1_op[a]) : r_p1_op[a];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_p2_op[a]  <= r_p1_op[a];
            r_p2_mag[a] <= p2_neg[a][MAG_W-1:0];
        end
        r_p2_r <= r_p1_r;
    end

    // P3: partial products
    logic signed [DIR_W+32:0]   r_p3_pl [3];   // low 32 bits of op times d
    logic signed [OP_W-32+DIR_W-1:0] r_p3_ph [3];
    logic [MAG_W-1:0]           r_p3_hh [3];
    logic [MAG_W-1:0]           r_p3_hl [3];
    logic [MAG_W-1:0]           r_p3_ll [3];
    logic [2*(RAD_W-24)-1:0]    r_p3_rhh;
    logic [RAD_W-1:0]           r_p3_rhl;
    logic [47:0]                r_p3_rll;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_p3_pl[a] <= $signed({1'b0, r_p2_op[a][31:0]}) * r_dir[a];
            r_p3_ph[a] <= $signed(r_p2_op[a][OP_W-1:32]) * r_dir[a];
            r_p3_hh[a] <= r_p2_mag[a][MAG_W-1:24] * r_p2_mag[a][MAG_W-1:24];
            r_p3_hl[a] <= r_p2_mag[a][MAG_W-1:24] * r_p2_mag[a][23:0];
            r_p3_ll[a] <= r_p2_mag[a][23:0] * r_p2_mag[a][23:0];
        end
        r_p3_rhh <= r_p2_r[RAD_W-1:24] * r_p2_r[RAD_W-1:24];
        r_p3_rhl <= r_p2_r[RAD_W-1:24] * r_p2_r[23:0];
        r_p3_rll <= r_p2_r[23:0] * r_p2_r[23:0];
    end

    // P4: full products
    logic signed [BP_W-1:0] r_p4_bp [3];
    logic [SQ_O_W-1:0]      r_p4_sq [3];
    logic [RR_W-1:0]        r_p4_rr;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_p4_bp[a] <= (BP_W'(r_p3_ph[a]) <<< 32) + BP_W'(r_p3_pl[a]);
            r_p4_sq[a] <= (SQ_O_W'(r_p3_hh[a]) << 48) + (SQ_O_W'(r_p3_hl[a]) << 25)
                          + SQ_O_W'(r_p3_ll[a]);
        end
        r_p4_rr <= (RR_W'(r_p3_rhh) << 48) + (RR_W'(r_p3_rhl) << 25) + RR_W'(r_p3_rll);
    end

    // P5: b = sum of floor(op_i * d_i / 2^30), op.op
    logic signed [B_W-1:0] r_p5_b;
    logic [NN_W-1:0]       r_p5_nn;
    logic [RR_W-1:0]       r_p5_rr;

    always_ff @(posedge i_clk) begin
        r_p5_b  <= B_W'($signed(r_p4_bp[0][BP_W-1:30])) + B_W'($signed(r_p4_bp[1][BP_W-1:30]))
                   + B_W'($signed(r_p4_bp[2][BP_W-1:30]));
        r_p5_nn <= NN_W'(r_p4_sq[0]) + NN_W'(r_p4_sq[1]) + NN_W'(r_p4_sq[2]);
        r_p5_rr <= r_p4_rr;
    end

    // P6: |b|
    logic signed [B_W-1:0] r_p6_b;
    logic [BM_W-1:0]       r_p6_bm;
    logic [NN_W-1:0]       r_p6_nn;
    logic [RR_W-1:0]       r_p6_rr;
    logic [B_W-1:0]        p6_abs;

    assign p6_abs = r_p5_b[B_W-1] ? (B_W'(0) - r_p5_b) : r_p5_b;

    always_ff @(posedge i_clk) begin
        r_p6_b  <= r_p5_b;
        r_p6_bm <= p6_abs[BM_W-1:0];
        r_p6_nn <= r_p5_nn;
        r_p6_rr <= r_p5_rr;
    end

    // P7: b^2 partials
    logic signed [B_W-1:0]    r_p7_b;
    logic [2*(BM_W-24)-1:0]   r_p7_hh;
    logic [BM_W-1:0]          r_p7_hl;
    logic [47:0]              r_p7_ll;
    logic [NN_W-1:0]          r_p7_nn;
    logic [RR_W-1:0]          r_p7_rr;

    always_ff @(posedge i_clk) begin
        r_p7_b  <= r_p6_b;
        r_p7_hh <= r_p6_bm[BM_W-1:24] * r_p6_bm[BM_W-1:24];
        r_p7_hl <= r_p6_bm[BM_W-1:24] * r_p6_bm[23:0];
        r_p7_ll <= r_p6_bm[23:0] * r_p6_bm[23:0];
        r_p7_nn <= r_p6_nn;
        r_p7_rr <= r_p6_rr;
    end

    // P8: b^2
    logic signed [B_W-1:0] r_p8_b;
    logic [BB_W-1:0]       r_p8_bb;
    logic [NN_W-1:0]       r_p8_nn;
    logic [RR_W-1:0]       r_p8_rr;

    always_ff @(posedge i_clk) begin
        r_p8_b  <= r_p7_b;
        r_p8_bb <= (BB_W'(r_p7_hh) << 48) + (BB_W'(r_p7_hl) << 25) + BB_W'(r_p7_ll);
        r_p8_nn <= r_p7_nn;
        r_p8_rr <= r_p7_rr;
    end

    // P9: b^2 + r^2
    logic signed [B_W-1:0] r_p9_b;
    logic [DET_W-1:0]      r_p9_pos;
    logic [NN_W-1:0]       r_p9_nn;

    always_ff @(posedge i_clk) begin
        r_p9_b   <= r_p8_b;
        r_p9_pos <= DET_W'(r_p8_bb) + DET_W'(r_p8_rr);
        r_p9_nn  <= r_p8_nn;
    end

    // det = pos - op.op; negative means a miss
    logic [DET_W:0] det_diff;

    assign det_diff = {1'b0, r_p9_pos} - {1'b0, DET_W'(r_p9_nn)};

    always_ff @(posedge i_clk) begin
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_det[0]  <= det_diff[DET_W-1:0];
        r_sq_b[0]    <= r_p9_b;
        r_sq_ok[0]   <= !det_diff[DET_W];
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_W; k++) begin : g_sq
        logic [R_W-1:0] rem_sh, trial;
        logic [R_W:0]   step_diff;

        always_comb begin
            rem_sh    = {r_sq_rem[k][R_W-3:0], r_sq_det[k][DET_W-1 -: 2]};
            trial     = {r_sq_root[k], 2'b01};
            step_diff = {1'b0, rem_sh} - {1'b0, trial};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_rem[k+1]  <= step_diff[R_W] ? rem_sh : step_diff[R_W-1:0];
            r_sq_root[k+1] <= {r_sq_root[k][SQ_W-2:0], !step_diff[R_W]};
            r_sq_det[k+1]  <= {r_sq_det[k][DET_W-3:0], 2'b00};
            r_sq_b[k+1]    <= r_sq_b[k];
            r_sq_ok[k+1]   <= r_sq_ok[k];
            r_sq_idx[k+1]  <= r_sq_idx[k];
            r_sq_last[k+1] <= r_sq_last[k];
        end
    end

    // T1: near and far distances
    logic signed [T_W-1:0] r_t1_lo, r_t1_hi;
    logic                  r_t1_ok;
    logic signed [T_W-1:0] sq_s;

    assign sq_s = $signed(T_W'(r_sq_root[SQ_W]));

    always_ff @(posedge i_clk) begin
        r_t1_lo <= T_W'(r_sq_b[SQ_W]) - sq_s;
        r_t1_hi <= T_W'(r_sq_b[SQ_W]) + sq_s;
        r_t1_ok <= r_sq_ok[SQ_W];
    end

    // T2: pick the nearer distance beyond min_distance
    logic signed [T_W-1:0] lim_t;
    logic                  lo_gt, hi_gt;

    assign lim_t = $signed(T_W'(r_min_distance));
    assign lo_gt = r_t1_lo > lim_t;
    assign hi_gt = r_t1_hi > lim_t;

    always_ff @(posedge i_clk) begin
        r_t2_t  <= lo_gt ? r_t1_lo : r_t1_hi;
        r_t2_ok <= r_t1_ok && (lo_gt || hi_gt);
    end

    // ---------------- nearest-hit accumulator ----------------
    logic                  r_acc_found;
    logic signed [T_W-1:0] r_acc_best;
    logic [IDX_W-1:0]      r_acc_idx;
    logic                  acc_take;

    assign acc_take = r_t2_v && r_t2_ok && (!r_acc_found || (r_t2_t < r_acc_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_found <= 1'b0;
        end else if (ray_fire) begin
            r_acc_found <= 1'b0;
        end else if (acc_take) begin
            r_acc_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_take) begin
            r_acc_best <= r_t2_t;
            r_acc_idx  <= r_t2_idx;
        end
    end

    // ---------------- response register ----------------
    logic           r_out_valid;
    rsnh_pkg::t_rsp r_out;
    rsnh_pkg::t_rsp rsp_next;
    logic [8:0]     best_idx_ext;

    assign best_idx_ext = 9'(r_acc_idx);

    always_comb begin
        rsp_next.hit          = r_acc_found;
        rsp_next.hit_index    = '0;
        rsp_next.hit_distance = '0;
        if (r_acc_found) begin
            rsp_next.hit_index = best_idx_ext[rsnh_pkg::ENTRY_W-1:0];
            rsp_next.hit_distance = (|r_acc_best[T_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                                : r_acc_best[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= rsp_next;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // ---------------- assertions ----------------
    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t2_v && r_t2_last) |=> (r_state == rsnh_pkg::ST_DONE))
        else $error("last sphere result did not close the scan");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsnh_pkg::ST_IDLE) |-> (!r_p0_v && !r_t2_v))
        else $error("pipeline busy while idle");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> ($past(r_state) == rsnh_pkg::ST_DONE))
        else $error("response raised outside of done state");

endmodule

// ----- hw/rtl/rsnh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rsnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sim/tb_ray_sphere_nearest_hit.sv -----
// Self-checking testbench for ray_sphere_nearest_hit: directed table, then random scenes.
module tb_ray_sphere_nearest_hit;

    localparam logic [rsnh_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int   N_ENT   = rsnh_pkg::MAX_SPHERES_DEF;
    localparam int   SETTLE  = 120;     // longest scan plus margin
    localparam longint UNIT  = 64'sd65536;
    localparam longint DIR1  = 64'sd1073741824;
    localparam logic [rsnh_pkg::DIST_W-1:0] DIST_MAX = {rsnh_pkg::DIST_W{1'b1}};

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_req_valid;
    logic                            o_req_ready;
    rsnh_pkg::t_req                  i_req;
    logic                            o_rsp_valid;
    logic                            i_rsp_ready;
    rsnh_pkg::t_rsp                  o_rsp;
    logic                            i_cfg_we;
    logic [rsnh_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rsnh_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ray_sphere_nearest_hit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Shadow copy of the sphere table and registers
    logic signed [rsnh_pkg::PT_W-1:0] shadow_cx [N_ENT];
    logic signed [rsnh_pkg::PT_W-1:0] shadow_cy [N_ENT];
    logic signed [rsnh_pkg::PT_W-1:0] shadow_cz [N_ENT];
    logic [rsnh_pkg::RAD_W-1:0]       shadow_rad [N_ENT];
    logic [rsnh_pkg::CNT_W-1:0]       shadow_count;
    logic [rsnh_pkg::MIN_W-1:0]       shadow_min;

    rsnh_pkg::t_rsp hits_pending[$];
    int   mismatches;
    bit   idling_on;
    bit   long_hold_req;

    typedef struct {
        rsnh_pkg::t_req req;
        bit             lit;
        rsnh_pkg::t_rsp hit_lit;
    } t_row;

    function automatic rsnh_pkg::t_rsp nearest_hit(rsnh_pkg::t_req r);
        logic signed [127:0] ox, oy, oz, b, rr, det, t, best, lim, s;
        logic [127:0]        ud, root, cand;
        int                  n;
        bit                  found;
        int                  best_i;
        rsnh_pkg::t_rsp      res;
        found  = 1'b0;
        best   = 0;
        best_i = 0;
        lim    = 0;
        lim[rsnh_pkg::MIN_W-1:0] = shadow_min;
        n = (shadow_count > N_ENT) ? N_ENT : int'(shadow_count);
        for (int i = n - 1; i >= 0; i--) begin
            ox = $signed(shadow_cx[i]);
            ox = ox - $signed(r.point_x);
            oy = $signed(shadow_cy[i]);
            oy = oy - $signed(r.point_y);
            oz = $signed(shadow_cz[i]);
            oz = oz - $signed(r.point_z);
            b = ((ox * $signed(r.dir_x)) >>> 30) + ((oy * $signed(r.dir_y)) >>> 30)
              + ((oz * $signed(r.dir_z)) >>> 30);
            rr = 0;
            rr[rsnh_pkg::RAD_W-1:0] = shadow_rad[i];
            det = b * b + rr * rr - (ox * ox + oy * oy + oz * oz);
            if (det >= 0) begin
                ud = det;
                root = 0;
                for (int k = 63; k >= 0; k--) begin
                    cand = root | (128'd1 << k);
                    if (cand * cand <= ud)
                        root = cand;
                end
                s = root;
                t = b - s;
                if (!(t > lim))
                    t = b + s;
                if (t > lim && (!found || t < best)) begin
                    found  = 1'b1;
                    best   = t;
                    best_i = i;
                end
            end
        end
        res = '0;
        if (found) begin
            res.hit       = 1'b1;
            res.hit_index = best_i[rsnh_pkg::ENTRY_W-1:0];
            res.hit_distance = (best > $signed({81'd0, DIST_MAX})) ? DIST_MAX
                                                   : best[rsnh_pkg::DIST_W-1:0];
        end
        return res;
    endfunction

    // Record an accepted request in the shadow model
    task automatic accept_req(rsnh_pkg::t_req r, bit lit, rsnh_pkg::t_rsp hit_lit);
        if (r.command == rsnh_pkg::CMD_LOAD) begin
            shadow_cx[r.entry_index]  = r.point_x;
            shadow_cy[r.entry_index]  = r.point_y;
            shadow_cz[r.entry_index]  = r.point_z;
            shadow_rad[r.entry_index] = r.sphere_size;
        end else begin
            hits_pending.push_back(lit ? hit_lit : nearest_hit(r));
        end
    endtask

    task automatic send_req(rsnh_pkg::t_req r, bit lit, rsnh_pkg::t_rsp hit_lit);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        accept_req(r, lit, hit_lit);
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [rsnh_pkg::CFG_IDX_W-1:0] idx,
                             logic [rsnh_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == rsnh_pkg::CFG_SPHERE_COUNT)
            shadow_count = data[rsnh_pkg::CNT_W-1:0];
        else if (idx == rsnh_pkg::CFG_MIN_DISTANCE)
            shadow_min = data[rsnh_pkg::MIN_W-1:0];
    endtask

    function automatic longint sym(longint m);
        return longint'($urandom_range(0, 32'(2 * m))) - m;
    endfunction

    function automatic longint rnd32();
        return longint'($urandom);
    endfunction

    function automatic rsnh_pkg::t_req mk(logic cmd, int e, longint x, longint y, longint z,
                                          longint rad, longint dx, longint dy, longint dz);
        rsnh_pkg::t_req r;
        r.command     = cmd;
        r.entry_index = e[rsnh_pkg::ENTRY_W-1:0];
        r.point_x     = x[rsnh_pkg::PT_W-1:0];
        r.point_y     = y[rsnh_pkg::PT_W-1:0];
        r.point_z     = z[rsnh_pkg::PT_W-1:0];
        r.sphere_size = rad[rsnh_pkg::RAD_W-1:0];
        r.dir_x       = dx[rsnh_pkg::DIR_W-1:0];
        r.dir_y       = dy[rsnh_pkg::DIR_W-1:0];
        r.dir_z       = dz[rsnh_pkg::DIR_W-1:0];
        return r;
    endfunction

    // Ray from a random origin, mostly aimed near one of the scanned spheres
    function automatic rsnh_pkg::t_req aimed_ray();
        longint ox, oy, oz;
        real    vx, vy, vz, nrm;
        int     n, e;
        ox = sym(50 * UNIT);
        oy = sym(50 * UNIT);
        oz = sym(50 * UNIT);
        n = (shadow_count > N_ENT) ? N_ENT : int'(shadow_count);
        e = (n == 0) ? 0 : $urandom_range(0, n - 1);
        vx = real'(shadow_cx[e] - ox + sym(4 * UNIT));
        vy = real'(shadow_cy[e] - oy + sym(4 * UNIT));
        vz = real'(shadow_cz[e] - oz + sym(4 * UNIT));
        nrm = $sqrt(vx * vx + vy * vy + vz * vz);
        if (nrm < 1.0 || $urandom_range(0, 9) == 0)
            return mk(rsnh_pkg::CMD_RAY, $urandom_range(0, 15), ox, oy, oz,
                      {$urandom, $urandom}, DIR1, 0, 0);
        return mk(rsnh_pkg::CMD_RAY, $urandom_range(0, 15), ox, oy, oz, {$urandom, $urandom},
                  $rtoi(vx / nrm * 1073741000.0), $rtoi(vy / nrm * 1073741000.0),
                  $rtoi(vz / nrm * 1073741000.0));
    endfunction

    function automatic rsnh_pkg::t_req rand_load();
        if ($urandom_range(0, 7) == 0)
            return mk(rsnh_pkg::CMD_LOAD, $urandom_range(0, 15), {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      rnd32(), rnd32(), rnd32());
        return mk(rsnh_pkg::CMD_LOAD, $urandom_range(0, 15), sym(50 * UNIT), sym(50 * UNIT),
                  sym(50 * UNIT), longint'($urandom_range(32'(UNIT / 4), 32'(8 * UNIT))),
                  rnd32(), rnd32(), rnd32());
    endfunction

    // Response checker and receiver stalls
    int stall_left;
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (hits_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", o_rsp);
            end else begin
                rsnh_pkg::t_rsp want;
                want = hits_pending.pop_front();
                if (o_rsp.hit !== want.hit || o_rsp.hit_index !== want.hit_index
                        || o_rsp.hit_distance !== want.hit_distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected hit=%0d idx=%0d dist=%0d, ",
                                  "got hit=%0d idx=%0d dist=%0d"},
                                 want.hit, want.hit_index, want.hit_distance,
                                 o_rsp.hit, o_rsp.hit_index, o_rsp.hit_distance);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_rsp_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = 400;
            i_rsp_ready  <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left   = $urandom_range(0, 9);
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    initial begin
        #2000000;
        $display("tb_ray_sphere_nearest_hit NOT OK");
        $finish;
    end

    t_row rows[$];
    rsnh_pkg::t_rsp miss;

    initial begin
        rsnh_pkg::t_req r;
        int   cnt_pick, n_items;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        i_rsp_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        mismatches  = 0;
        idling_on   = 1'b1;
        long_hold_req = 1'b0;
        stall_left  = 0;
        miss        = '0;
        for (int i = 0; i < N_ENT; i++) begin
            shadow_cx[i] = '0;
            shadow_cy[i] = '0;
            shadow_cz[i] = '0;
            shadow_rad[i] = '0;
        end
        shadow_count = '0;
        shadow_min   = rsnh_pkg::MIN_DIST_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: nothing scanned after reset, then five sphere loads of which four are scanned
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, 0, 0, 0, 0, DIR1, 0, 0), 1, miss});
        rows.push_back('{mk(rsnh_pkg::CMD_LOAD, 0, 0, 0, 0, UNIT, 0, 0, 0), 0, miss});
        rows.push_back('{mk(rsnh_pkg::CMD_LOAD, 1, 10 * UNIT, 0, 0, 2 * UNIT, 0, 0, 0),
                         0, miss});
        rows.push_back('{mk(rsnh_pkg::CMD_LOAD, 2, 10 * UNIT, 0, 0, 2 * UNIT, 0, 0, 0),
                         0, miss});
        rows.push_back('{mk(rsnh_pkg::CMD_LOAD, 3, 64'sh7FFF_FFFF_FFFF, 100 * UNIT, 0, UNIT,
                            0, 0, 0), 0, miss});
        rows.push_back('{mk(rsnh_pkg::CMD_LOAD, 4, 64'sh8000_0000_0000, 64'sh8000_0000_0000,
                            64'sh7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF, -1, -1, -1), 0, miss});
        // count still 0
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, 0, 0, 0, 0, DIR1, 0, 0), 1, miss});
        foreach (rows[i])
            send_req(rows[i].req, rows[i].lit, rows[i].hit_lit);
        rows.delete();
        drain();
        cfg_write(rsnh_pkg::CFG_SPHERE_COUNT, 16'd4);
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, 0, 0, -5 * UNIT, 0, 0, 0, DIR1), 0, miss});
        // origin inside a sphere: far root taken
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, 0, 0, 0, 0, DIR1, 0, 0), 0, miss});
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, -20 * UNIT, 0, 0, 0, DIR1, 0, 0), 0, miss});
        // two identical spheres: higher index wins
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, 5 * UNIT, 0, 0, 0, DIR1, 0, 0), 0, miss});
        // pointing away from everything
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, 0, 0, -5 * UNIT, 0, 0, 0, -DIR1), 1, miss});
        // far hit, distance saturates
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 15, 64'sh8000_0000_0000, 100 * UNIT, 0, 0,
                            DIR1, 0, 0), 1, '{1'b1, 4'd3, DIST_MAX}});
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, 0, 0, 0, 0, -64'sd2147483648,
                            64'sd2147483647, -64'sd2147483648), 0, miss});
        rows.push_back('{mk(rsnh_pkg::CMD_RAY, 0, 64'sh7FFF_FFFF_FFFF, 64'sh8000_0000_0000,
                            0, 0, -DIR1, DIR1, 0), 0, miss});
        foreach (rows[i])
            send_req(rows[i].req, rows[i].lit, rows[i].hit_lit);

        // Fill the rest of the table before wider scans
        for (int e = 5; e < N_ENT; e++) begin
            r = rand_load();
            r.entry_index = e[rsnh_pkg::ENTRY_W-1:0];
            send_req(r, 0, miss);
        end

        for (int ph = 0; ph < 10; ph++) begin
            drain();
            case (ph)
                0: cfg_write(rsnh_pkg::CFG_SPHERE_COUNT, 16'd16);
                1: cfg_write(rsnh_pkg::CFG_SPHERE_COUNT, 16'd1);
                2: cfg_write(rsnh_pkg::CFG_SPHERE_COUNT, 16'hFFFF);   // masks to 31, scans 16
                3: cfg_write(rsnh_pkg::CFG_SPHERE_COUNT, 16'd17);
                4: cfg_write(rsnh_pkg::CFG_SPHERE_COUNT, 16'd0);
                default: begin
                    cnt_pick = $urandom_range(1, 16);
                    cfg_write(rsnh_pkg::CFG_SPHERE_COUNT, 16'(cnt_pick));
                end
            endcase
            case (ph % 4)
                0: cfg_write(rsnh_pkg::CFG_MIN_DISTANCE, 16'd0);
                1: cfg_write(rsnh_pkg::CFG_MIN_DISTANCE, 16'hFFFF);
                2: cfg_write(rsnh_pkg::CFG_MIN_DISTANCE, rsnh_pkg::MIN_DIST_RST);
                default: cfg_write(rsnh_pkg::CFG_MIN_DISTANCE, 16'($urandom));
            endcase
            if (ph == 6)
                cfg_write(CFG_UNUSED, 16'($urandom));
            idling_on = (ph < 8);
            n_items = (ph == 4) ? 40 : 140;
            for (int k = 0; k < n_items; k++) begin
                if (ph == 2 && k == 10)
                    long_hold_req = 1'b1;
                case ($urandom_range(0, 19))
                    0, 1: send_req(rand_load(), 0, miss);
                    2: send_req(mk(rsnh_pkg::CMD_RAY, $urandom_range(0, 15),
                                   {$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom}, {$urandom, $urandom},
                                   rnd32(), rnd32(), rnd32()),
                                0, miss);
                    default: send_req(aimed_ray(), 0, miss);
                endcase
            end
        end
        drain();
        if (mismatches == 0 && hits_pending.size() == 0)
            $display("tb_ray_sphere_nearest_hit OK");
        else
            $display("tb_ray_sphere_nearest_hit NOT OK");
        $finish;
    end

endmodule

// ----- ray_sphere_nearest_hit.f -----
hw/rtl/rsnh_pkg.sv
hw/rtl/rsnh_ram.sv
hw/rtl/ray_sphere_nearest_hit.sv
sim/tb_ray_sphere_nearest_hit.sv
